/* src/trend_pattern_match_counter_top_defines.svh */
// assertion macros used by the top-level rtl file
`ifndef TREND_PATTERN_MATCH_COUNTER_TOP_DEFINES_SVH
`define TREND_PATTERN_MATCH_COUNTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TPMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define TPMC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define TPMC_ASSERT(label, clk, rst_n, prop)
`define TPMC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* src/tpmc_pkg.sv */
package tpmc_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int SYMBOL_SLOTS  = 16;

    localparam int SAMPLE_FIELD_W = 32;
    localparam int SAMPLE_USED_W  = (SAMPLE_WIDTH < SAMPLE_FIELD_W) ? SAMPLE_WIDTH
                                                                     : SAMPLE_FIELD_W;
    localparam int LEN_W       = 5;
    localparam int PATTERN_W   = 32;
    localparam int COUNT_W     = 32;
    localparam int SEEN_W      = $clog2(PATTERN_MAX + 1);
    localparam int CFG_INDEX_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef logic [1:0] sym_t;

    localparam sym_t SYM_DOWN  = 2'd0;
    localparam sym_t SYM_EQUAL = 2'd1;
    localparam sym_t SYM_UP    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_SYMBOLS = 4'd1;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // pattern symbol that lines up with history slot idx for the given length
    function automatic sym_t want_symbol(input logic [PATTERN_W-1:0] pat,
                                         input logic [LEN_W-1:0] len,
                                         input int idx);
        int k;
        logic [PATTERN_W-1:0] sh;
        begin
            k  = int'(len) - 1 - idx;
            sh = '0;
            if (k >= 0 && k < SYMBOL_SLOTS)
            begin
                sh = pat >> (2 * k);
            end
            return sh[1:0];
        end
    endfunction

endpackage

/* src/tpmc_cell.sv */
module tpmc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  tpmc_pkg::cell_ctrl_t ctrl,
    input  tpmc_pkg::sym_t     sym_in,
    input  tpmc_pkg::sym_t     want,
    input  logic               care,
    output tpmc_pkg::sym_t     sym_out,
    output logic               hit_ok
);
    import tpmc_pkg::*;

    sym_t sym_reg;
    sym_t sym_next;

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            sym_next = SYM_DOWN;
        end
        else if (ctrl.shift)
        begin
            sym_next = sym_in;
        end
        else
        begin
            sym_next = sym_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg <= SYM_DOWN;
        end
        else
        begin
            sym_reg <= sym_next;
        end
    end

    // compare the symbol this slot holds after the shift
    assign hit_ok  = !care || (sym_in == want);
    assign sym_out = sym_reg;

endmodule

/* src/trend_pattern_match_counter_top.sv */
// trend pattern match counter
// input channel: sample and start_of_sequence, transfer on in_valid & in_ready.
// output channel: window_matches and match_count, transfer on
// out_valid & out_ready, exactly one result for every input transfer.
// config channel: cfg_index 0 writes pattern_length, 1 writes pattern_symbols;
// other indices are dropped. cfg_ready is always high.
// each sample is classed down, equal or up against the previous one and
// shifted into a row of sixteen symbol cells, a start_of_sequence sample clears
// it instead; every cell compares its symbol with the pattern symbol for its slot, results and-ed.
// the result appears in the output register in the cycle after the input
// transfer. throughput: one sample per cycle while the receiver takes each
// result, set by the compare, shift and count update done in the transfer cycle.
// a stalled receiver holds the output register; in_ready then drops until
// the held result is taken, so nothing is lost.
// reset: pattern_length 1, pattern_symbols 0, history, symbol count,
// running count and previous sample cleared, no result pending.
`include "trend_pattern_match_counter_top_defines.svh"

module trend_pattern_match_counter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [tpmc_pkg::SAMPLE_FIELD_W-1:0] sample,
    input  logic                                start_of_sequence,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                window_matches,
    output logic [tpmc_pkg::COUNT_W-1:0]        match_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tpmc_pkg::PATTERN_W-1:0]      cfg_data
);
    import tpmc_pkg::*;

    logic [LEN_W-1:0]         pattern_length_reg;
    logic [PATTERN_W-1:0]     pattern_symbols_reg;
    logic [SAMPLE_USED_W-1:0] prev_sample_reg;
    logic [SEEN_W-1:0]        seen_reg;
    logic [SEEN_W-1:0]        seen_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     window_matches_reg;

    logic                     accept;
    logic [SAMPLE_USED_W-1:0] cur_sample;
    sym_t                     sym_new;
    cell_ctrl_t               ctrl;
    logic                     len_ok;
    logic                     hit;

    sym_t                     chain [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]   cell_ok;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg  <= LEN_W'(1);
            pattern_symbols_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LENGTH:  pattern_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_PATTERN_SYMBOLS: pattern_symbols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign cur_sample = sample[SAMPLE_USED_W-1:0];

    always_comb
    begin
        priority if (cur_sample > prev_sample_reg)
        begin
            sym_new = SYM_UP;
        end
        else if (cur_sample == prev_sample_reg)
        begin
            sym_new = SYM_EQUAL;
        end
        else
        begin
            sym_new = SYM_DOWN;
        end
    end

    assign ctrl.shift = accept && !start_of_sequence;
    assign ctrl.clear = accept && start_of_sequence;

    // row of symbol cells, newest symbol in cell 0
    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            sym_t cell_in;
            if (gi == 0)
            begin : g_head
                assign cell_in = sym_new;
            end
            else
            begin : g_link
                assign cell_in = chain[gi-1];
            end

            tpmc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .sym_in  (cell_in),
                .want    (want_symbol(pattern_symbols_reg, pattern_length_reg, gi)),
                .care    (gi < int'(pattern_length_reg)),
                .sym_out (chain[gi]),
                .hit_ok  (cell_ok[gi])
            );
        end
    endgenerate

    always_comb
    begin
        seen_next = seen_reg;
        if (ctrl.clear)
        begin
            seen_next = '0;
        end
        else if (ctrl.shift && int'(seen_reg) < PATTERN_MAX)
        begin
            seen_next = seen_reg + SEEN_W'(1);
        end
    end

    assign len_ok = (pattern_length_reg != '0)
                 && (int'(pattern_length_reg) <= PATTERN_MAX)
                 && (int'(pattern_length_reg) <= SYMBOL_SLOTS);

    assign hit = ctrl.shift && len_ok && &cell_ok
              && (int'(seen_next) >= int'(pattern_length_reg));

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (hit && count_reg != COUNT_MAX)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sample_reg <= '0;
            seen_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                prev_sample_reg <= cur_sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_matches_reg <= hit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign window_matches = window_matches_reg;
    assign match_count    = count_reg;

    `TPMC_ASSERT(a_count_steps_on_hit, clk, rst_n,
        (hit && count_reg != COUNT_MAX) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
    `TPMC_ASSERT(a_start_clears, clk, rst_n,
        ctrl.clear |=> (count_reg == '0 && seen_reg == '0 && !window_matches_reg))
    `TPMC_ASSERT_NEVER(a_match_with_zero_count, clk, rst_n,
        out_valid_reg && window_matches_reg && count_reg == '0)
    `TPMC_ASSERT_NEVER(a_seen_overflow, clk, rst_n,
        int'(seen_reg) > PATTERN_MAX)

endmodule
